// ----- rtl/core/lmc_pkg.sv -----
`timescale 1ns / 1ps

package lmc_pkg;

   localparam int KEY_W            = 32;
   localparam int COUNT_W          = 32;
   localparam int CAP_W            = 5;
   localparam int ENTRIES_DEFAULT  = 16;
   localparam int KEY_BITS_DEFAULT = 32;

   localparam logic [CAP_W-1:0]   CAPACITY_RESET = CAP_W'(16);
   localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

endpackage

// ----- rtl/core/lmc_if.sv -----
`timescale 1ns / 1ps

interface lmc_req_if;
   logic                       valid;
   logic                       ready;
   logic [lmc_pkg::KEY_W-1:0]  key;

   modport source (output valid, output key, input ready);
   modport sink   (input valid, input key, output ready);
endinterface

interface lmc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [lmc_pkg::COUNT_W-1:0] miss_count;

   modport source (output valid, output hit, output miss_count, input ready);
   modport sink   (input valid, input hit, input miss_count, output ready);
endinterface

interface lmc_csr_if;
   logic                      valid;
   logic                      ready;
   logic [lmc_pkg::CAP_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/lru_cache_miss_counter.sv -----
`timescale 1ns / 1ps

// Fully associative LRU key store with a saturating miss counter. Each request item
// carries one key and yields exactly one response item: a hit flag and the number of
// misses since reset, this access included, saturating at all ones. Capacity (1..16,
// zero acts as one, values above the entry count are clipped) sets how many entries
// fill before the least recent one is evicted; lowering it below the current
// occupancy evicts one entry per miss and never shrinks the store. The block takes
// one item per cycle unless the response output is stalled: a key is registered on
// acceptance, then, once the output is free, all entries are compared and their
// recency ranks updated at once, with the response registered at the end of that
// cycle.
// The store is empty after reset and the capacity register is write-only, always ready,
// and should only be written while no items are in flight.
module lru_cache_miss_counter #(
   parameter int ENTRIES  = lmc_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS = lmc_pkg::KEY_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   lmc_req_if.sink   req_ch,
   lmc_rsp_if.source rsp_ch,
   lmc_csr_if.sink   csr_ch
);

   localparam int TAG_W = (KEY_BITS < lmc_pkg::KEY_W) ? KEY_BITS : lmc_pkg::KEY_W;

   logic [lmc_pkg::CAP_W-1:0]   capacity_ff;
   logic                        in_valid_ff;
   logic [TAG_W-1:0]            tag_ff;
   logic                        rsp_valid_ff;
   logic                        hit_ff;
   logic [lmc_pkg::COUNT_W-1:0] count_ff;
   logic [lmc_pkg::COUNT_W-1:0] miss_ff;
   logic [lmc_pkg::COUNT_W-1:0] miss_in;
   logic                        advance;
   logic                        fire;
   logic                        hit;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;
   assign fire         = in_valid_ff && advance;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.hit        = hit_ff;
   assign rsp_ch.miss_count = count_ff;

   lmc_store #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .capacity (capacity_ff),
      .fire     (fire),
      .tag      (tag_ff),
      .hit      (hit)
   );

   // saturating miss count including this item
   always_comb begin
      miss_in = miss_ff;
      if (!hit && (miss_ff != lmc_pkg::COUNT_MAX)) begin
         miss_in = miss_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= lmc_pkg::CAPACITY_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         miss_ff      <= '0;
      end else begin
         if (csr_ch.valid) begin
            capacity_ff <= csr_ch.data;
         end
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            miss_ff      <= miss_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         tag_ff <= req_ch.key[TAG_W-1:0];
      end
      if (fire) begin
         hit_ff   <= hit;
         count_ff <= miss_in;
      end
   end

endmodule

// ----- rtl/core/lmc_store.sv -----
`timescale 1ns / 1ps

module lmc_store #(
   parameter int ENTRIES  = lmc_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS = lmc_pkg::KEY_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [lmc_pkg::CAP_W-1:0] capacity,
   input  logic                      fire,
   input  logic [((KEY_BITS < lmc_pkg::KEY_W) ? KEY_BITS : lmc_pkg::KEY_W)-1:0] tag,
   output logic                      hit
);

   localparam int TAG_W = (KEY_BITS < lmc_pkg::KEY_W) ? KEY_BITS : lmc_pkg::KEY_W;
   localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CW    = (OCC_W > lmc_pkg::CAP_W) ? OCC_W : lmc_pkg::CAP_W;

   logic [TAG_W-1:0]   key_ff   [ENTRIES];
   logic [AGE_W-1:0]   age_ff   [ENTRIES];
   logic [AGE_W-1:0]   age_in   [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [OCC_W-1:0]   occ_ff;
   logic [OCC_W-1:0]   occ_in;

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] evict;
   logic [ENTRIES-1:0] free_vec;
   logic [ENTRIES-1:0] free_oh;
   logic [ENTRIES-1:0] ins;
   logic [AGE_W-1:0]   hit_age;
   logic [OCC_W-1:0]   oldest;
   logic [CW-1:0]      cap_x;
   logic [CW-1:0]      eff_cap;
   logic               full;

   // effective capacity: zero acts as one, clipped to the entry count
   always_comb begin
      cap_x = CW'(capacity);
      if (cap_x == '0) begin
         eff_cap = CW'(1);
      end else if (cap_x > CW'(ENTRIES)) begin
         eff_cap = CW'(ENTRIES);
      end else begin
         eff_cap = cap_x;
      end
      full = CW'(occ_ff) >= eff_cap;
   end

   always_comb begin
      hit_age  = '0;
      oldest   = occ_ff - 1'b1;
      free_vec = ~valid_ff;
      free_oh  = free_vec & (~free_vec + 1'b1);
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == tag);
         evict[i] = valid_ff[i] && (OCC_W'(age_ff[i]) == oldest);
         hit_age  = hit_age | (match[i] ? age_ff[i] : '0);
      end
      hit = |match;
      ins = full ? evict : free_oh;
   end

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         age_in[i] = age_ff[i];
      end
      if (fire) begin
         if (hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (match[i]) begin
                  age_in[i] = '0;
               end else if (valid_ff[i] && (age_ff[i] < hit_age)) begin
                  age_in[i] = age_ff[i] + 1'b1;
               end
            end
         end else begin
            // new key goes in as most recent, every other live entry ages by one
            for (int i = 0; i < ENTRIES; i++) begin
               if (ins[i]) begin
                  valid_in[i] = 1'b1;
                  age_in[i]   = '0;
               end else if (valid_ff[i]) begin
                  age_in[i] = age_ff[i] + 1'b1;
               end
            end
            if (!full) begin
               occ_in = occ_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (fire && !hit && ins[i]) begin
            key_ff[i] <= tag;
         end
      end
   end

endmodule

// ----- rtl/core/lmc_checker.sv -----
`timescale 1ns / 1ps

module lmc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_hit,
   input logic [lmc_pkg::COUNT_W-1:0] rsp_miss_count,
   input logic                        csr_ready
);

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_miss_count))
      else $error("stalled response changed");

   // an accepted item is answered once the output is free
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 (!rsp_valid || rsp_ready) |=> rsp_valid)
      else $error("response missing after accepted item");

   // a hit never moves the miss count
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 rsp_valid && rsp_hit |-> rsp_miss_count == $past(rsp_miss_count))
      else $error("miss count changed on hit");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("capacity write stalled");

endmodule

bind lru_cache_miss_counter lmc_checker u_lmc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_hit        (rsp_ch.hit),
   .rsp_miss_count (rsp_ch.miss_count),
   .csr_ready      (csr_ch.ready)
);
